[rtl/core/rcad_pkg.sv]
// Shared types, constants and delta tables for the run-coded ADPCM byte decoder.
// No dependencies; used by rcad_front, rcad_queue, rcad_back and the decoder top.
`default_nettype none

package rcad_pkg;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [15:0] SampleInit = 16'h0080;

  // Header byte mode field (bits 7..6)
  localparam logic [1:0] HdrPair    = 2'd0;
  localparam logic [1:0] HdrNibble  = 2'd1;
  localparam logic [1:0] HdrLiteral = 2'd2;
  localparam logic [1:0] HdrRepeat  = 2'd3;

  // Work item handed from the parser to the executor
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_REPEAT,
    CMD_DELTA,
    CMD_LITERAL,
    CMD_NIBBLE,
    CMD_PAIR,
    CMD_RAW
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  arg;
    logic        start;
    logic [15:0] size;
  } cmd_t;

  function automatic logic signed [4:0] delta4(input logic [3:0] nib);
    logic signed [4:0] d;
    case (nib)
      4'd0:    d = -5'sd9;
      4'd1:    d = -5'sd8;
      4'd2:    d = -5'sd6;
      4'd3:    d = -5'sd5;
      4'd4:    d = -5'sd4;
      4'd5:    d = -5'sd3;
      4'd6:    d = -5'sd2;
      4'd7:    d = -5'sd1;
      4'd8:    d = 5'sd0;
      4'd9:    d = 5'sd1;
      4'd10:   d = 5'sd2;
      4'd11:   d = 5'sd3;
      4'd12:   d = 5'sd4;
      4'd13:   d = 5'sd5;
      4'd14:   d = 5'sd6;
      default: d = 5'sd8;
    endcase
    return d;
  endfunction

  // {-2, -1, 0, 1}
  function automatic logic signed [4:0] delta2(input logic [1:0] pr);
    return $signed({3'b000, pr}) - 5'sd2;
  endfunction

  // Two's complement 16-bit sample clipped to 0..255
  function automatic logic [7:0] clip8(input logic [15:0] s);
    logic [7:0] v;
    if (s[15]) begin
      v = 8'h00;
    end else if (|s[14:8]) begin
      v = 8'hFF;
    end else begin
      v = s[7:0];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rcad_front.sv]
// Byte parser: tracks header/data state and turns each accepted byte into a command.
// Depends on rcad_pkg.
`default_nettype none

module rcad_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          chunk_start_i,
  input  wire logic          raw_chunk_i,
  input  wire logic [15:0]   chunk_size_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output rcad_pkg::cmd_t     q_cmd_o
);
  import rcad_pkg::*;

  typedef enum logic [1:0] {
    PM_HEADER,
    PM_LITERAL,
    PM_NIBBLE,
    PM_PAIR
  } parse_mode_e;

  parse_mode_e mode_q, mode_d, mode_eff;
  logic [5:0]  bytes_q, bytes_d, bytes_eff;
  logic        pass_q, pass_d, pass_eff;
  logic        accept;
  cmd_t        cmd;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;
  assign q_cmd_o    = cmd;

  always_comb begin
    mode_eff  = chunk_start_i ? PM_HEADER : mode_q;
    bytes_eff = chunk_start_i ? 6'd0 : bytes_q;
    pass_eff  = chunk_start_i ? raw_chunk_i : pass_q;

    mode_d  = mode_eff;
    bytes_d = bytes_eff;
    pass_d  = pass_eff;

    cmd.kind  = CMD_NONE;
    cmd.arg   = data_byte_i;
    cmd.start = chunk_start_i;
    cmd.size  = chunk_size_i;

    if (pass_eff) begin
      cmd.kind = CMD_RAW;
    end else begin
      case (mode_eff)
        PM_HEADER: begin
          case (data_byte_i[7:6])
            HdrRepeat: begin
              cmd.kind = CMD_REPEAT;
            end
            HdrLiteral: begin
              if (data_byte_i[5]) begin
                cmd.kind = CMD_DELTA;
              end else begin
                mode_d  = PM_LITERAL;
                bytes_d = data_byte_i[5:0];
              end
            end
            HdrNibble: begin
              mode_d  = PM_NIBBLE;
              bytes_d = data_byte_i[5:0];
            end
            default: begin
              mode_d  = PM_PAIR;
              bytes_d = data_byte_i[5:0];
            end
          endcase
        end
        PM_LITERAL, PM_NIBBLE, PM_PAIR: begin
          case (mode_eff)
            PM_LITERAL: cmd.kind = CMD_LITERAL;
            PM_NIBBLE:  cmd.kind = CMD_NIBBLE;
            default:    cmd.kind = CMD_PAIR;
          endcase
          if (bytes_eff == 6'd0) begin
            mode_d = PM_HEADER;
          end else begin
            bytes_d = bytes_eff - 6'd1;
          end
        end
        default: begin
          mode_d = PM_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= PM_HEADER;
      bytes_q <= 6'd0;
      pass_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      bytes_q <= bytes_d;
      pass_q  <= pass_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rcad_queue.sv]
// Small command queue between parser and executor.
// Depends on rcad_pkg (cmd_t, QueueDepth).
`default_nettype none

module rcad_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  rcad_pkg::cmd_t     cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output rcad_pkg::cmd_t     cmd_o
);
  import rcad_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rcad_back.sv]
// Executor: holds the running sample and output count, emits one sample per cycle
// into an output register when the output is not stalled. Depends on rcad_pkg.
`default_nettype none

module rcad_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  rcad_pkg::cmd_t     q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_sample_o,
  output logic               run_last_o,
  output logic               chunk_done_o
);
  import rcad_pkg::*;

  logic              busy_q;
  cmd_t              cmd_q;
  logic [5:0]        step_q, last_step;
  logic [15:0]       sample_q, left_q, left_eff, left_dec;
  logic [15:0]       sum, new_sample;
  logic signed [4:0] delta;
  logic [7:0]        value;
  logic              ov_q, olast_q, odone_q;
  logic [7:0]        osample_q;
  logic              out_free, pop, fire, fin;

  assign out_free = !ov_q || out_ready_i;
  assign pop      = !busy_q && q_valid_i;
  assign fire     = busy_q && out_free;
  assign q_pop_o  = pop;
  assign left_eff = q_cmd_i.start ? q_cmd_i.size : left_q;
  assign left_dec = left_q - 16'd1;

  always_comb begin
    case (cmd_q.kind)
      CMD_REPEAT: last_step = cmd_q.arg[5:0];
      CMD_NIBBLE: last_step = 6'd1;
      CMD_PAIR:   last_step = 6'd3;
      default:    last_step = 6'd0;
    endcase

    case (cmd_q.kind)
      CMD_DELTA:  delta = $signed(cmd_q.arg[4:0]);
      CMD_NIBBLE: delta = delta4(step_q[0] ? cmd_q.arg[7:4] : cmd_q.arg[3:0]);
      CMD_PAIR: begin
        case (step_q[1:0])
          2'd0:    delta = delta2(cmd_q.arg[1:0]);
          2'd1:    delta = delta2(cmd_q.arg[3:2]);
          2'd2:    delta = delta2(cmd_q.arg[5:4]);
          default: delta = delta2(cmd_q.arg[7:6]);
        endcase
      end
      default:    delta = 5'sd0;
    endcase

    sum = sample_q + {{11{delta[4]}}, delta};

    case (cmd_q.kind)
      CMD_LITERAL:         new_sample = {8'h00, cmd_q.arg};
      CMD_REPEAT, CMD_RAW: new_sample = sample_q;
      default:             new_sample = sum;
    endcase

    case (cmd_q.kind)
      CMD_LITERAL, CMD_RAW: value = cmd_q.arg;
      default:              value = clip8(new_sample);
    endcase

    // stop early when the chunk runs out mid-byte
    fin = (step_q == last_step) || (left_dec == 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cmd_q     <= '0;
      step_q    <= 6'd0;
      sample_q  <= SampleInit;
      left_q    <= 16'd0;
      ov_q      <= 1'b0;
      osample_q <= 8'h00;
      olast_q   <= 1'b0;
      odone_q   <= 1'b0;
    end else begin
      if (pop) begin
        cmd_q  <= q_cmd_i;
        step_q <= 6'd0;
        if (q_cmd_i.start) begin
          sample_q <= SampleInit;
          left_q   <= q_cmd_i.size;
        end
        busy_q <= (q_cmd_i.kind != CMD_NONE) && (left_eff != 16'd0);
      end
      if (fire) begin
        sample_q  <= new_sample;
        left_q    <= left_dec;
        step_q    <= step_q + 6'd1;
        ov_q      <= 1'b1;
        osample_q <= value;
        olast_q   <= fin;
        odone_q   <= (left_dec == 16'd0);
        if (fin) begin
          busy_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_sample_o = osample_q;
  assign run_last_o   = olast_q;
  assign chunk_done_o = odone_q;

endmodule

`default_nettype wire

[rtl/core/run_coded_adpcm_byte_decoder_unit.sv]
// The first sample of a byte passes through the command queue, the executor's
// command register and the output register. The executor takes a command, then
// emits its samples (up to 64 for a repeat header) before it takes the next one.
// A 2-entry command queue lets the parser take bytes while samples drain.
// Reset (rst_ni low, async): no chunk open, sample 128, parser at header, queue empty.
// Depends on rcad_pkg, rcad_front, rcad_queue, rcad_back.
`default_nettype none

module run_coded_adpcm_byte_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] chunk_size
  input  wire logic [1:0]  s_axis_tuser,  // [0] chunk_start, [1] raw_chunk
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_sample
  output logic             m_axis_tlast,  // run_last
  output logic             m_axis_tuser   // [0] chunk_done
);
  import rcad_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  rcad_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .data_byte_i   (s_axis_tdata[7:0]),
    .chunk_start_i (s_axis_tuser[0]),
    .raw_chunk_i   (s_axis_tuser[1]),
    .chunk_size_i  (s_axis_tdata[23:8]),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  rcad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  rcad_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (head_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata),
    .run_last_o   (m_axis_tlast),
    .chunk_done_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

[rtl/core/rcad_checker.sv]
// Port-level checks for the decoder top level, attached by bind.
// Depends on run_coded_adpcm_byte_decoder_unit port names only.
`default_nettype none

module rcad_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // end of chunk always closes the byte's run
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("chunk_done without run_last");

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

endmodule

bind run_coded_adpcm_byte_decoder_unit rcad_props u_rcad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[sim/rcad_checker.sv]
// Scoreboard for the run-coded ADPCM byte decoder: watches both stream ports,
// predicts the sample stream from accepted input bytes and compares every output transfer.
// Depends on rcad_pkg for the header mode codes.
module rcad_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] chunk_size
  input  logic [1:0]  s_axis_tuser,  // [0] chunk_start, [1] raw_chunk
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,  // [7:0] out_sample
  input  logic        m_axis_tlast,  // run_last
  input  logic        m_axis_tuser,  // [0] chunk_done
  output int          fail_count,
  output int          pending,
  output int          live_items
);
  timeunit 1ns;
  timeprecision 1ps;

  import rcad_pkg::*;

  typedef enum logic [1:0] {PS_HEADER, PS_LITERAL, PS_NIBBLE, PS_PAIR} parse_e;

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
    logic       done;
  } sample_rec_t;

  localparam logic signed [4:0] NibStep [16] = '{
    -5'sd9, -5'sd8, -5'sd6, -5'sd5, -5'sd4, -5'sd3, -5'sd2, -5'sd1,
    5'sd0, 5'sd1, 5'sd2, 5'sd3, 5'sd4, 5'sd5, 5'sd6, 5'sd8
  };
  localparam logic signed [4:0] PairStep [4] = '{-5'sd2, -5'sd1, 5'sd0, 5'sd1};

  logic [15:0] smp;
  parse_e      pstate;
  logic [5:0]  data_left;
  logic [15:0] out_left;
  logic        raw_mode;

  sample_rec_t sample_q[$];
  sample_rec_t byte_batch[$];

  function automatic logic [15:0] widen(input logic signed [4:0] d);
    return {{11{d[4]}}, d};
  endfunction

  // two's complement sample clamped to an unsigned byte
  function automatic logic [7:0] sat8(input logic [15:0] s);
    if (s[15]) return 8'h00;
    if (s > 16'd255) return 8'hFF;
    return s[7:0];
  endfunction

  task put_sample(input logic [7:0] v);
    sample_rec_t r;
    if (out_left == 16'd0) return;
    out_left = out_left - 16'd1;
    r.sample = v;
    r.last   = 1'b0;
    r.done   = (out_left == 16'd0);
    byte_batch.push_back(r);
  endtask

  task next_data;
    if (data_left == 6'd0) pstate = PS_HEADER;
    else data_left = data_left - 6'd1;
  endtask

  task decode_byte(input logic [7:0] b, input logic st, input logic raw,
                   input logic [15:0] sz);
    int k;
    sample_rec_t r;
    byte_batch.delete();
    live_items++;
    if (st) begin
      smp       = 16'd128;
      pstate    = PS_HEADER;
      data_left = 6'd0;
      raw_mode  = raw;
      out_left  = sz;
    end
    if (out_left == 16'd0) return;
    if (raw_mode) begin
      put_sample(b);
    end else begin
      case (pstate)
        PS_HEADER: begin
          case (b[7:6])
            HdrRepeat: begin
              for (k = 0; k <= int'(b[5:0]); k++) put_sample(sat8(smp));
            end
            HdrLiteral: begin
              if (b[5]) begin
                smp = smp + widen(b[4:0]);
                put_sample(sat8(smp));
              end else begin
                pstate    = PS_LITERAL;
                data_left = b[5:0];
              end
            end
            HdrNibble: begin
              pstate    = PS_NIBBLE;
              data_left = b[5:0];
            end
            default: begin
              pstate    = PS_PAIR;
              data_left = b[5:0];
            end
          endcase
        end
        PS_LITERAL: begin
          smp = {8'h00, b};
          put_sample(b);
          next_data();
        end
        PS_NIBBLE: begin
          smp = smp + widen(NibStep[b[3:0]]);
          put_sample(sat8(smp));
          smp = smp + widen(NibStep[b[7:4]]);
          put_sample(sat8(smp));
          next_data();
        end
        default: begin
          for (k = 0; k < 4; k++) begin
            smp = smp + widen(PairStep[b[2*k +: 2]]);
            put_sample(sat8(smp));
          end
          next_data();
        end
      endcase
    end
    if (byte_batch.size() > 0) begin
      r = byte_batch[byte_batch.size() - 1];
      r.last = 1'b1;
      byte_batch[byte_batch.size() - 1] = r;
    end
    foreach (byte_batch[k]) sample_q.push_back(byte_batch[k]);
  endtask

  task flag_error(input sample_rec_t want, input logic have_want);
    if (fail_count < 10) begin
      if (have_want)
        $display("%0t: mismatch: expected sample %02h last %0b done %0b, got %02h %0b %0b",
                 $realtime, want.sample, want.last, want.done,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
      else
        $display("%0t: unexpected sample %02h last %0b done %0b", $realtime,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_rec_t want;
    if (!rst_ni) begin
      smp        = 16'd128;
      pstate     = PS_HEADER;
      data_left  = 6'd0;
      out_left   = 16'd0;
      raw_mode   = 1'b0;
      sample_q.delete();
      fail_count = 0;
      pending    = 0;
      live_items = 0;
    end else begin
      // input side first so a byte's samples are queued before any compare
      if (s_axis_tvalid && s_axis_tready)
        decode_byte(s_axis_tdata[7:0], s_axis_tuser[0], s_axis_tuser[1],
                    s_axis_tdata[23:8]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (sample_q.size() == 0) begin
          want = '0;
          flag_error(want, 1'b0);
        end else begin
          want = sample_q.pop_front();
          if (m_axis_tdata !== want.sample || m_axis_tlast !== want.last ||
              m_axis_tuser !== want.done)
            flag_error(want, 1'b1);
        end
      end
      pending = sample_q.size();
    end
  end

endmodule

[sim/tb.sv]
// Top of the decoder testbench: clock, reset, byte stimulus and output backpressure.
// Checking lives in rcad_checker; depends on rcad_pkg and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcad_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [7:0] data_byte, [23:8] chunk_size
  logic [1:0]  s_axis_tuser = '0;  // [0] chunk_start, [1] raw_chunk
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [7:0] out_sample
  logic        m_axis_tlast;       // run_last
  logic        m_axis_tuser;       // [0] chunk_done

  logic gaps_on = 1'b1;
  int   fail_count;
  int   pending;
  int   live_items;

  run_coded_adpcm_byte_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  rcad_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .live_items    (live_items)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // sample sink backpressure
  always @(negedge clk_i) begin
    if (!gaps_on) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) >= 7);
  end

  // One byte transfer. Off chunk start, the size and raw fields carry noise.
  task automatic push_byte(input logic [7:0] b, input logic st, input logic raw,
                           input logic [15:0] sz);
    logic        r_raw;
    logic [15:0] r_sz;
    r_raw = st ? raw : 1'($urandom_range(0, 1));
    r_sz  = st ? sz : 16'($urandom);
    while (gaps_on && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {r_sz, b};
    s_axis_tuser  = {r_raw, st};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [5:0] pick_count();
    if ($urandom_range(0, 99) < 6) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 5));
  endfunction

  // Mostly well-formed chunk, raw or of header/data runs with random payload; some
  // truncated runs, stray bytes and chunk restarts on top.
  task automatic random_chunk();
    logic        raw;
    logic [15:0] sz;
    logic [7:0]  hdr;
    logic [5:0]  cnt;
    int          r, nblk, ndata, k, j;
    r = $urandom_range(0, 99);
    if (r < 8) sz = 16'd0;
    else if (r < 11) sz = 16'hFFFF;
    else if (r < 18) sz = 16'($urandom);
    else if (r < 55) sz = 16'($urandom_range(1, 24));
    else sz = 16'($urandom_range(25, 400));
    raw = ($urandom_range(0, 99) < 15);
    if (raw) begin
      push_byte(8'($urandom), 1'b1, 1'b1, sz);
      repeat ($urandom_range(1, 20)) push_byte(8'($urandom), 1'b0, 1'b0, 16'd0);
    end else begin
      nblk = $urandom_range(1, 10);
      for (k = 0; k < nblk; k++) begin
        cnt   = pick_count();
        ndata = 0;
        r     = $urandom_range(0, 99);
        if (r < 15) begin
          hdr = {HdrRepeat, cnt};
        end else if (r < 30) begin
          hdr = {HdrLiteral, 1'b1, 5'($urandom)};
        end else if (r < 50) begin
          hdr   = {HdrLiteral, 1'b0, cnt[4:0]};
          ndata = cnt[4:0] + 1;
        end else if (r < 75) begin
          hdr   = {HdrNibble, cnt};
          ndata = cnt + 1;
        end else begin
          hdr   = {HdrPair, cnt};
          ndata = cnt + 1;
        end
        push_byte(hdr, (k == 0), 1'b0, sz);
        if (ndata > 0 && $urandom_range(0, 99) < 8) ndata = $urandom_range(0, ndata - 1);
        for (j = 0; j < ndata; j++) push_byte(8'($urandom), 1'b0, 1'b0, 16'd0);
        if ($urandom_range(0, 99) < 5) push_byte(8'($urandom), 1'b0, 1'b0, 16'd0);
      end
    end
    if ($urandom_range(0, 99) < 15)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'b0, 16'd0);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing open after reset, then an empty chunk
    push_byte(8'h33, 1'b0, 1'b0, 16'd0);
    push_byte({HdrRepeat, 6'd5}, 1'b1, 1'b0, 16'd0);
    // repeat, both delta signs, literal extremes, chunk ending inside a nibble byte
    push_byte({HdrRepeat, 6'd2}, 1'b1, 1'b0, 16'd8);
    push_byte({HdrLiteral, 1'b1, 5'h1F}, 1'b0, 1'b0, 16'd0);
    push_byte({HdrLiteral, 1'b1, 5'h0F}, 1'b0, 1'b0, 16'd0);
    push_byte({HdrLiteral, 6'd1}, 1'b0, 1'b0, 16'd0);
    push_byte(8'h00, 1'b0, 1'b0, 16'd0);
    push_byte(8'hFF, 1'b0, 1'b0, 16'd0);
    push_byte({HdrNibble, 6'd0}, 1'b0, 1'b0, 16'd0);
    push_byte(8'hF0, 1'b0, 1'b0, 16'd0);
    push_byte(8'h12, 1'b0, 1'b0, 16'd0);  // after chunk end: dropped
    // 2-bit deltas, lowest and highest steps
    push_byte({HdrPair, 6'd1}, 1'b1, 1'b0, 16'd20);
    push_byte(8'h00, 1'b0, 1'b0, 16'd0);
    push_byte(8'hFF, 1'b0, 1'b0, 16'd0);
    // clamp at zero and at full scale
    push_byte({HdrLiteral, 6'd0}, 1'b1, 1'b0, 16'd30);
    push_byte(8'h02, 1'b0, 1'b0, 16'd0);
    push_byte({HdrPair, 6'd0}, 1'b0, 1'b0, 16'd0);
    push_byte(8'h00, 1'b0, 1'b0, 16'd0);
    push_byte({HdrRepeat, 6'd0}, 1'b0, 1'b0, 16'd0);
    push_byte({HdrLiteral, 6'd0}, 1'b0, 1'b0, 16'd0);
    push_byte(8'hFF, 1'b0, 1'b0, 16'd0);
    push_byte({HdrLiteral, 1'b1, 5'h0F}, 1'b0, 1'b0, 16'd0);
    // uncompressed chunk
    push_byte(8'h5A, 1'b1, 1'b1, 16'd3);
    push_byte(8'hA5, 1'b0, 1'b0, 16'd0);
    push_byte(8'h00, 1'b0, 1'b0, 16'd0);
    // longest repeat run
    push_byte({HdrRepeat, 6'd63}, 1'b1, 1'b0, 16'd100);

    // hold off until the sink has drained everything
    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);

    while (live_items < 430) begin
      gaps_on = !(live_items >= 150 && live_items < 260);
      random_chunk();
    end
    s_axis_tvalid = 1'b0;
    gaps_on = 1'b1;

    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/core/rcad_pkg.sv
rtl/core/rcad_front.sv
rtl/core/rcad_queue.sv
rtl/core/rcad_back.sv
rtl/core/run_coded_adpcm_byte_decoder_unit.sv
rtl/core/rcad_checker.sv
sim/rcad_checker.sv
sim/tb.sv
